[rtl/crp_pkg.sv]
`default_nettype none
package crp_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int SCREEN_BITS = 12;

  localparam logic [2:0] CFG_HALF_SIZE = 3'd0;
  localparam logic [2:0] CFG_FOCAL_SCALE = 3'd1;
  localparam logic [2:0] CFG_CENTER_X = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y = 3'd3;
  localparam logic [2:0] CFG_ANGLE_STEP = 3'd4;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_CW = 2'd1;
  localparam logic [1:0] OP_CCW = 2'd2;

  localparam logic [6:0] HALF_SIZE_RST = 7'd20;
  localparam logic [7:0] FOCAL_SCALE_RST = 8'd40;
  localparam logic [9:0] CENTER_X_RST = 10'd120;
  localparam logic [9:0] CENTER_Y_RST = 10'd160;
  localparam logic [15:0] ANGLE_STEP_RST = 16'd590;

  localparam logic [9:0] DEPTH_MIN = 10'd29;
  localparam logic [9:0] DEPTH_MAX = 10'd1023;
  localparam logic [9:0] DEPTH_RST = 10'd30;

  localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;

  // Datapath widths of the rotation and projection stages.
  localparam int CW = 35;
  localparam int SUMW = 36;
  localparam int PW = 44;
  localparam int NW = 53;
  localparam int ZTW = 45;
  localparam int ZW = 44;

  localparam logic signed [CW-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [CW-1:0] TWO_PI_Q30 = 35'sd6746518852;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30 = 35'sd652032874;
  localparam logic [4:0] CORDIC_LAST = 5'd29;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0: r = 30'd843314857;
      5'd1: r = 30'd497837829;
      5'd2: r = 30'd263043837;
      5'd3: r = 30'd133525159;
      5'd4: r = 30'd67021687;
      5'd5: r = 30'd33543516;
      5'd6: r = 30'd16775851;
      5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194283;
      5'd9: r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/crp_if.sv]
`default_nettype none
interface crp_in_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic switch_pressed;
  modport source(output valid, op, switch_pressed, input ready);
  modport sink(input valid, op, switch_pressed, output ready);
endinterface

interface crp_out_if #(parameter int SB = crp_pkg::SCREEN_BITS);
  logic valid;
  logic ready;
  logic [2:0] vertex_index;
  logic signed [SB-1:0] screen_x;
  logic signed [SB-1:0] screen_y;
  logic [9:0] depth_now;
  logic mode_now;
  logic last;
  modport source(output valid, vertex_index, screen_x, screen_y, depth_now, mode_now, last,
                 input ready);
  modport sink(input valid, vertex_index, screen_x, screen_y, depth_now, mode_now, last,
               output ready);
endinterface
`default_nettype wire

[rtl/cube_rotate_project_core.sv]
`default_nettype none
// Channel | Dir | Payload                                         | Beat when
// in_i    | in  | op, switch_pressed                              | valid & ready
// out_o   | out | vertex_index, screen_x/y, depth_now, mode_now,  | valid & ready
//         |     | last                                            |
// cfg     | in  | cfg_idx_i, cfg_data_i                           | cfg_we_i
// A tick is taken in the idle state, then angle_step is reduced below 2pi by
// repeated subtraction before the tick is queued. Each tick then costs set-up,
// rotation steps and 8 points, each held by the bit-per-cycle quotient units
// plus any output stall.
// A two-entry queue lets new ticks enter while points wait on a stalled output.
// Reset is asynchronous and active low; no clearing pass is needed.
module cube_rotate_project_core #(
  parameter int ANGLE_FRAC_BITS = crp_pkg::ANGLE_FRAC_BITS,
  parameter int SCREEN_BITS = crp_pkg::SCREEN_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  crp_in_if.sink           in_i,
  crp_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int QW = AW + 11;

  logic [6:0] half_size_q;
  logic [7:0] focal_scale_q;
  logic [9:0] center_x_q, center_y_q;
  logic [15:0] angle_step_q;

  logic push_valid, push_ready, pop_valid, pop_ready;
  logic [AW-1:0] f_phase;
  logic [9:0] f_depth;
  logic f_mode;
  logic [QW-1:0] pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_size_q <= crp_pkg::HALF_SIZE_RST;
      focal_scale_q <= crp_pkg::FOCAL_SCALE_RST;
      center_x_q <= crp_pkg::CENTER_X_RST;
      center_y_q <= crp_pkg::CENTER_Y_RST;
      angle_step_q <= crp_pkg::ANGLE_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crp_pkg::CFG_HALF_SIZE: half_size_q <= cfg_data_i[6:0];
        crp_pkg::CFG_FOCAL_SCALE: focal_scale_q <= cfg_data_i[7:0];
        crp_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i[9:0];
        crp_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i[9:0];
        crp_pkg::CFG_ANGLE_STEP: angle_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crp_front #(.AF(ANGLE_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_i, .angle_step_i(angle_step_q),
    .push_valid_o(push_valid), .push_ready_i(push_ready),
    .push_phase_o(f_phase), .push_depth_o(f_depth), .push_mode_o(f_mode)
  );

  crp_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready),
    .push_data_i({f_mode, f_depth, f_phase}),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_data_o(pop_data)
  );

  crp_back #(.AF(ANGLE_FRAC_BITS), .SB(SCREEN_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(pop_valid), .q_ready_o(pop_ready),
    .q_phase_i(pop_data[AW-1:0]), .q_depth_i(pop_data[AW+9:AW]), .q_mode_i(pop_data[QW-1]),
    .half_size_i(half_size_q), .focal_scale_i(focal_scale_q),
    .center_x_i(center_x_q), .center_y_i(center_y_q),
    .out_o
  );
endmodule
`default_nettype wire

[rtl/crp_front.sv]
`default_nettype none
module crp_front #(
  parameter int AF = crp_pkg::ANGLE_FRAC_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  crp_in_if.sink             in_i,
  input  wire logic [15:0]   angle_step_i,
  output logic               push_valid_o,
  input  wire logic          push_ready_i,
  output logic [AF+2:0]      push_phase_o,
  output logic [9:0]         push_depth_o,
  output logic               push_mode_o
);
  localparam int AW = AF + 3;
  localparam int SW = (AW > 16) ? AW : 16;
  localparam logic [63:0] TPF = (crp_pkg::TWO_PI_Q32 + (64'd1 << (31 - AF))) >> (32 - AF);
  localparam logic [SW-1:0] TP_S = SW'(TPF);
  localparam logic [AW:0] TP_W = (AW + 1)'(TPF);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RED = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic [SW-1:0] st_q, st_d;
  logic [AW-1:0] phase_q, phase_d;
  logic [9:0] depth_q, depth_d;
  logic mode_q, mode_d;
  logic [AW:0] sum_cw, sum_ccw;

  always_comb begin
    sum_cw = {1'b0, phase_q} + (AW + 1)'(st_q);
    if (sum_cw >= TP_W) begin
      sum_cw = sum_cw - TP_W;
    end
    sum_ccw = {1'b0, phase_q} + TP_W - (AW + 1)'(st_q);
    if (sum_ccw >= TP_W) begin
      sum_ccw = sum_ccw - TP_W;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    st_d = st_q;
    phase_d = phase_q;
    depth_d = depth_q;
    mode_d = mode_q;
    in_i.ready = 1'b0;
    push_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          mode_d = mode_q ^ in_i.switch_pressed;
          op_d = in_i.op;
          st_d = SW'(angle_step_i);
          state_d = F_RED;
        end
      end
      F_RED: begin
        if (st_q >= TP_S) begin
          st_d = st_q - TP_S;
        end else begin
          state_d = F_PUSH;
          if (op_q == crp_pkg::OP_CW || op_q == crp_pkg::OP_CCW) begin
            if (mode_q) begin
              phase_d = (op_q == crp_pkg::OP_CW) ? sum_cw[AW-1:0] : sum_ccw[AW-1:0];
            end else if (op_q == crp_pkg::OP_CW) begin
              if (depth_q < crp_pkg::DEPTH_MAX) depth_d = depth_q + 10'd1;
            end else begin
              if (depth_q > crp_pkg::DEPTH_MIN) depth_d = depth_q - 10'd1;
            end
          end
        end
      end
      F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      phase_q <= AW'(1) << (AF - 1);
      depth_q <= crp_pkg::DEPTH_RST;
      mode_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      depth_q <= depth_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    st_q <= st_d;
  end

  assign push_phase_o = phase_q;
  assign push_depth_o = depth_q;
  assign push_mode_o = mode_q;
endmodule
`default_nettype wire

[rtl/crp_queue.sv]
`default_nettype none
module crp_queue #(
  parameter int W = crp_pkg::ANGLE_FRAC_BITS + 14
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  wire logic [W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output logic [W-1:0]      pop_data_o
);
  logic [W-1:0] mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push = push_valid_i && push_ready_o;
  assign do_pop = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end
endmodule
`default_nettype wire

[rtl/crp_div.sv]
`default_nettype none
module crp_div #(
  parameter int QB = crp_pkg::SCREEN_BITS + 2
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic signed [crp_pkg::NW-1:0]   num_i,
  input  wire logic [crp_pkg::ZW-1:0]          den_i,
  output logic                                 busy_o,
  output logic signed [QB:0]                   quo_o
);
  localparam int NW = crp_pkg::NW;
  localparam int ZW = crp_pkg::ZW;
  localparam int DW = (NW > ZW + QB) ? NW : ZW + QB;
  localparam int CNTW = $clog2(QB + 1);

  logic busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0] r_q, d_q, mag, dfull;
  logic [QB-1:0] q_q;
  logic neg_q;

  assign mag = DW'(num_i < 0 ? -num_i : num_i);
  assign dfull = DW'(den_i) << QB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= (mag < dfull);
    end else if (busy_q && cnt_q == CNTW'(1)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= (num_i < 0);
      r_q <= mag;
      d_q <= DW'(den_i) << (QB - 1);
      cnt_q <= CNTW'(QB);
      q_q <= (mag >= dfull) ? '1 : '0;
    end else if (busy_q) begin
      if (r_q >= d_q) begin
        r_q <= r_q - d_q;
        q_q <= {q_q[QB-2:0], 1'b1};
      end else begin
        q_q <= {q_q[QB-2:0], 1'b0};
      end
      d_q <= d_q >> 1;
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  assign busy_o = busy_q;
  assign quo_o = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
endmodule
`default_nettype wire

[rtl/crp_back.sv]
`default_nettype none
module crp_back #(
  parameter int AF = crp_pkg::ANGLE_FRAC_BITS,
  parameter int SB = crp_pkg::SCREEN_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  wire logic [AF+2:0] q_phase_i,
  input  wire logic [9:0]    q_depth_i,
  input  wire logic          q_mode_i,
  input  wire logic [6:0]    half_size_i,
  input  wire logic [7:0]    focal_scale_i,
  input  wire logic [9:0]    center_x_i,
  input  wire logic [9:0]    center_y_i,
  crp_out_if.source          out_o
);
  localparam int CW = crp_pkg::CW;
  localparam int SUMW = crp_pkg::SUMW;
  localparam int PW = crp_pkg::PW;
  localparam int NW = crp_pkg::NW;
  localparam int ZTW = crp_pkg::ZTW;
  localparam int ZW = crp_pkg::ZW;
  localparam int QB = SB + 2;
  localparam int VW = QB + 2;
  localparam logic signed [VW-1:0] SHI = VW'((1 << (SB - 1)) - 1);
  localparam logic signed [VW-1:0] SLO = -SHI - VW'(1);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_PREP = 4'd1;
  localparam logic [3:0] B_ROT = 4'd2;
  localparam logic [3:0] B_FIX = 4'd3;
  localparam logic [3:0] B_MUL1 = 4'd4;
  localparam logic [3:0] B_MUL2 = 4'd5;
  localparam logic [3:0] B_DIVGO = 4'd6;
  localparam logic [3:0] B_DIV = 4'd7;
  localparam logic [3:0] B_OUT = 4'd8;

  logic [3:0] state_q;
  logic [AF+2:0] phase_q;
  logic [9:0] depth_q;
  logic mode_q, neg_q;
  logic signed [CW-1:0] x_q, y_q, z_q, c_q, s_q;
  logic [4:0] it_q;
  logic [2:0] k_q;
  logic signed [PW-1:0] xr_q, zh_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic [ZW-1:0] zr_q;
  logic out_valid_q;
  logic signed [SB-1:0] sx_q, sy_q;

  logic signed [CW-1:0] z0, z1, z2, atan_w;
  logic neg_w;
  logic signed [CW-1:0] c_sel, s_sel, sc_sel, cc_sel;
  logic signed [SUMW-1:0] xsum, zsum;
  logic [14:0] hf;
  logic signed [15:0] hs;
  logic signed [ZTW-1:0] zt;
  logic div_go, bx, by;
  logic signed [QB:0] qx, qy;
  logic signed [VW-1:0] vx, vy;

  always_comb begin
    z0 = $signed(CW'(phase_q) << (30 - AF));
    z1 = (z0 >= crp_pkg::PI_Q30) ? z0 - crp_pkg::TWO_PI_Q30 : z0;
    neg_w = 1'b0;
    z2 = z1;
    if (z1 > crp_pkg::HALF_PI_Q30) begin
      z2 = z1 - crp_pkg::PI_Q30;
      neg_w = 1'b1;
    end else if (z1 < -crp_pkg::HALF_PI_Q30) begin
      z2 = z1 + crp_pkg::PI_Q30;
      neg_w = 1'b1;
    end
    atan_w = $signed({{(CW - 30){1'b0}}, crp_pkg::atan_q30(it_q)});
    c_sel = k_q[0] ? c_q : -c_q;
    s_sel = k_q[2] ? s_q : -s_q;
    sc_sel = k_q[0] ? s_q : -s_q;
    cc_sel = k_q[2] ? c_q : -c_q;
    xsum = SUMW'(c_sel) - SUMW'(s_sel);
    zsum = SUMW'(sc_sel) + SUMW'(cc_sel);
    hf = 15'(half_size_i) * 15'(focal_scale_i);
    hs = k_q[1] ? $signed({1'b0, hf}) : -$signed({1'b0, hf});
    zt = ZTW'(zh_q) + $signed(ZTW'(depth_q) << 30);
    vx = $signed(VW'(center_x_i)) + VW'(qx);
    vy = $signed(VW'(center_y_i)) + VW'(qy);
    if (vx > SHI) vx = SHI;
    if (vx < SLO) vx = SLO;
    if (vy > SHI) vy = SHI;
    if (vy < SLO) vy = SLO;
  end

  assign div_go = (state_q == B_DIVGO);
  assign q_ready_o = (state_q == B_IDLE);

  crp_div #(.QB(QB)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_go), .num_i(nx_q), .den_i(zr_q), .busy_o(bx), .quo_o(qx)
  );
  crp_div #(.QB(QB)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_go), .num_i(ny_q), .den_i(zr_q), .busy_o(by), .quo_o(qy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: if (q_valid_i) state_q <= B_PREP;
        B_PREP: state_q <= B_ROT;
        B_ROT: if (it_q == crp_pkg::CORDIC_LAST) state_q <= B_FIX;
        B_FIX: state_q <= B_MUL1;
        B_MUL1: state_q <= B_MUL2;
        B_MUL2: state_q <= B_DIVGO;
        B_DIVGO: state_q <= B_DIV;
        B_DIV: begin
          if (!bx && !by) begin
            state_q <= B_OUT;
            out_valid_q <= 1'b1;
          end
        end
        B_OUT: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            state_q <= (k_q == 3'd7) ? B_IDLE : B_MUL1;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        phase_q <= q_phase_i;
        depth_q <= q_depth_i;
        mode_q <= q_mode_i;
      end
      B_PREP: begin
        z_q <= z2;
        neg_q <= neg_w;
        x_q <= crp_pkg::GAIN_Q30;
        y_q <= '0;
        it_q <= '0;
      end
      B_ROT: begin
        if (z_q >= 0) begin
          x_q <= x_q - (y_q >>> it_q);
          y_q <= y_q + (x_q >>> it_q);
          z_q <= z_q - atan_w;
        end else begin
          x_q <= x_q + (y_q >>> it_q);
          y_q <= y_q - (x_q >>> it_q);
          z_q <= z_q + atan_w;
        end
        it_q <= it_q + 5'd1;
      end
      B_FIX: begin
        c_q <= neg_q ? -x_q : x_q;
        s_q <= neg_q ? -y_q : y_q;
        k_q <= 3'd0;
      end
      B_MUL1: begin
        xr_q <= $signed({1'b0, half_size_i}) * xsum;
        zh_q <= $signed({1'b0, half_size_i}) * zsum;
      end
      B_MUL2: begin
        nx_q <= xr_q * $signed({1'b0, focal_scale_i});
        ny_q <= NW'(hs) <<< 30;
        zr_q <= (zt < ZTW'(1)) ? ZW'(1) : zt[ZW-1:0];
      end
      B_DIV: begin
        sx_q <= vx[SB-1:0];
        sy_q <= vy[SB-1:0];
      end
      B_OUT: if (out_o.ready) k_q <= k_q + 3'd1;
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.vertex_index = k_q;
  assign out_o.screen_x = sx_q;
  assign out_o.screen_y = sy_q;
  assign out_o.depth_now = depth_q;
  assign out_o.mode_now = mode_q;
  assign out_o.last = (k_q == 3'd7);

  a_valid_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid == (state_q == B_OUT)) else $error("output valid outside output state");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_IDLE && q_valid_i) |=> (state_q == B_PREP))
    else $error("queued tick not taken");
  a_rot_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_ROT && it_q == crp_pkg::CORDIC_LAST) |=> (state_q == B_FIX))
    else $error("rotation did not end after last step");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && (bx || by)) |=> (state_q == B_DIV))
    else $error("result left before both quotients");
endmodule
`default_nettype wire

[bench/tb_cube_rotate_project_core.sv]
`timescale 1ns / 100ps

module tb_cube_rotate_project_core;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [2:0] vertex;
    logic signed [crp_pkg::SCREEN_BITS-1:0] sx;
    logic signed [crp_pkg::SCREEN_BITS-1:0] sy;
    logic [9:0] depth;
    logic mode;
    logic last;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  crp_in_if in_if ();
  crp_out_if out_if ();

  cube_rotate_project_core u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if),
    .out_o(out_if),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the block's registers and state.
  longint half_sh, focal_sh, cx_sh, cy_sh, step_sh;
  logic mode_sh;
  longint phase_sh;
  longint depth_sh;
  longint atan_tab [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2};

  point_t pending_points [$];
  int fails = 0;
  int idle_cycles = 0;
  bit burst_in = 1'b0;
  bit burst_out = 1'b0;

  function automatic longint two_pi_f();
    return (longint'(crp_pkg::TWO_PI_Q32) + (64'd1 << (31 - crp_pkg::ANGLE_FRAC_BITS)))
           >> (32 - crp_pkg::ANGLE_FRAC_BITS);
  endfunction

  function automatic void sin_cos(input longint phase, output longint c, output longint s);
    longint z, x, y, dx, dy, pi_q, hp_q;
    bit neg;
    pi_q = longint'(crp_pkg::PI_Q30);
    hp_q = longint'(crp_pkg::HALF_PI_Q30);
    z = phase <<< (30 - crp_pkg::ANGLE_FRAC_BITS);
    x = longint'(crp_pkg::GAIN_Q30);
    y = 0;
    neg = 1'b0;
    if (z >= pi_q) z = z - 2 * pi_q;
    if (z > hp_q) begin
      z = z - pi_q;
      neg = 1'b1;
    end else if (z < -hp_q) begin
      z = z + pi_q;
      neg = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic signed [crp_pkg::SCREEN_BITS-1:0] clamp_screen(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (crp_pkg::SCREEN_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[crp_pkg::SCREEN_BITS-1:0];
  endfunction

  task automatic predict_tick(input logic [1:0] op, input logic sw);
    longint c, s, h, f, dq, vx, vy, vz, xr, yr, zr, st, tp;
    point_t p;
    tp = two_pi_f();
    if (sw) mode_sh = ~mode_sh;
    if (op == crp_pkg::OP_CW || op == crp_pkg::OP_CCW) begin
      if (mode_sh) begin
        st = step_sh % tp;
        phase_sh = phase_sh % tp;
        if (op == crp_pkg::OP_CW) phase_sh = (phase_sh + st) % tp;
        else phase_sh = (phase_sh + tp - st) % tp;
      end else if (op == crp_pkg::OP_CW) begin
        if (depth_sh < longint'(crp_pkg::DEPTH_MAX)) depth_sh++;
      end else begin
        if (depth_sh > longint'(crp_pkg::DEPTH_MIN)) depth_sh--;
      end
    end
    sin_cos(phase_sh, c, s);
    h = half_sh;
    f = focal_sh;
    dq = depth_sh <<< 30;
    for (int k = 0; k < 8; k++) begin
      vx = k[0] ? h : -h;
      vy = k[1] ? h : -h;
      vz = k[2] ? h : -h;
      xr = vx * c - vz * s;
      zr = vx * s + vz * c + dq;
      yr = vy <<< 30;
      if (zr < 1) zr = 1;
      p.vertex = k[2:0];
      p.sx = clamp_screen(cx_sh + (xr * f) / zr);
      p.sy = clamp_screen(cy_sh + (yr * f) / zr);
      p.depth = depth_sh[9:0];
      p.mode = mode_sh;
      p.last = (k == 7);
      pending_points.push_back(p);
    end
  endtask

  task automatic send_tick(input logic [1:0] op, input logic sw);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.switch_pressed <= sw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_tick(op, sw);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[15:0];
    case (idx)
      crp_pkg::CFG_HALF_SIZE: half_sh = val & 'h7F;
      crp_pkg::CFG_FOCAL_SCALE: focal_sh = val & 'hFF;
      crp_pkg::CFG_CENTER_X: cx_sh = val & 'h3FF;
      crp_pkg::CFG_CENTER_Y: cy_sh = val & 'h3FF;
      crp_pkg::CFG_ANGLE_STEP: step_sh = val & 'hFFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input longint h, input longint f, input longint x,
                           input longint y, input longint st);
    write_reg(crp_pkg::CFG_HALF_SIZE, h);
    write_reg(crp_pkg::CFG_FOCAL_SCALE, f);
    write_reg(crp_pkg::CFG_CENTER_X, x);
    write_reg(crp_pkg::CFG_CENTER_Y, y);
    write_reg(crp_pkg::CFG_ANGLE_STEP, st);
  endtask

  task automatic test_reset_values();
    send_tick(crp_pkg::OP_NONE, 1'b0);
    send_tick(crp_pkg::OP_CW, 1'b0);
    send_tick(crp_pkg::OP_CCW, 1'b0);
    send_tick(2'd3, 1'b0);
    drain();
  endtask

  task automatic test_directed_cases();
    // Walk the depth down to its floor and past it with a large cube.
    write_all(127, 255, 1023, 0, 65535);
    repeat (3) send_tick(crp_pkg::OP_CCW, 1'b0);
    send_tick(crp_pkg::OP_CW, 1'b1);
    send_tick(crp_pkg::OP_CW, 1'b0);
    send_tick(crp_pkg::OP_CCW, 1'b0);
    send_tick(crp_pkg::OP_CCW, 1'b0);
    send_tick(2'd3, 1'b0);
    send_tick(crp_pkg::OP_NONE, 1'b1);
    send_tick(crp_pkg::OP_NONE, 1'b1);
    send_tick(crp_pkg::OP_CW, 1'b0);
    drain();
    write_all(1, 1, 0, 1023, 0);
    send_tick(crp_pkg::OP_CW, 1'b0);
    send_tick(crp_pkg::OP_CCW, 1'b1);
    drain();
    write_all(0, 0, 512, 512, 1);
    send_tick(crp_pkg::OP_CW, 1'b0);
    send_tick(crp_pkg::OP_CCW, 1'b0);
    send_tick(crp_pkg::OP_NONE, 1'b1);
    drain();
    write_all(100, 200, 1000, 20, 40000);
    repeat (4) send_tick(crp_pkg::OP_CCW, 1'b0);
    repeat (4) send_tick(crp_pkg::OP_CW, 1'b0);
    drain();
  endtask

  task automatic test_random_ticks();
    logic [1:0] op;
    logic sw;
    for (int phase = 0; phase < 4; phase++) begin
      write_all($urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 65535));
      burst_in = (phase == 1);
      burst_out = (phase == 2);
      for (int n = 0; n < 18; n++) begin
        op = 2'($urandom_range(0, 3));
        sw = ($urandom_range(0, 5) == 0);
        if (n == 9) begin
          @(negedge clk_i);
          in_if.valid <= 1'b0;
          while (pending_points.size() != 0) @(posedge clk_i);
        end
        send_tick(op, sw);
      end
      drain();
    end
    burst_in = 1'b0;
    burst_out = 1'b0;
  endtask

  task automatic test_depth_climb();
    write_all(127, 255, 0, 1023, 2);
    if (mode_sh) send_tick(crp_pkg::OP_NONE, 1'b1);
    burst_in = 1'b1;
    repeat (20) send_tick(crp_pkg::OP_CW, 1'b0);
    burst_in = 1'b0;
    send_tick(crp_pkg::OP_CCW, 1'b0);
    send_tick(crp_pkg::OP_CW, 1'b0);
    drain();
  endtask

  always @(posedge clk_i) begin
    point_t e;
    if (out_if.valid && out_if.ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point vertex=%0d x=%0d y=%0d", $time,
                 out_if.vertex_index, out_if.screen_x, out_if.screen_y);
        fails++;
      end else begin
        e = pending_points.pop_front();
        if (out_if.vertex_index !== e.vertex) begin
          $display("%0t: vertex_index expected %0d actual %0d", $time, e.vertex,
                   out_if.vertex_index);
          fails++;
        end
        if (out_if.screen_x !== e.sx) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, out_if.screen_x);
          fails++;
        end
        if (out_if.screen_y !== e.sy) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, out_if.screen_y);
          fails++;
        end
        if (out_if.depth_now !== e.depth) begin
          $display("%0t: depth_now expected %0d actual %0d", $time, e.depth,
                   out_if.depth_now);
          fails++;
        end
        if (out_if.mode_now !== e.mode) begin
          $display("%0t: mode_now expected %0d actual %0d", $time, e.mode, out_if.mode_now);
          fails++;
        end
        if (out_if.last !== e.last) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, out_if.last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = burst_out ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_if.valid && out_if.ready)) @(posedge clk_i);
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = crp_pkg::OP_NONE;
    in_if.switch_pressed = 1'b0;
    half_sh = crp_pkg::HALF_SIZE_RST;
    focal_sh = crp_pkg::FOCAL_SCALE_RST;
    cx_sh = crp_pkg::CENTER_X_RST;
    cy_sh = crp_pkg::CENTER_Y_RST;
    step_sh = crp_pkg::ANGLE_STEP_RST;
    mode_sh = 1'b0;
    phase_sh = longint'(1) <<< (crp_pkg::ANGLE_FRAC_BITS - 1);
    depth_sh = crp_pkg::DEPTH_RST;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_directed_cases();
    test_random_ticks();
    test_depth_climb();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/crp_pkg.sv
rtl/crp_if.sv
rtl/crp_front.sv
rtl/crp_queue.sv
rtl/crp_div.sv
rtl/crp_back.sv
rtl/cube_rotate_project_core.sv
bench/tb_cube_rotate_project_core.sv
